>>> hw/rtl/etg_pkg.sv
// -----------------------------------------------------------------------------
// etg_pkg
// Shared types and constants of the envelope table generator.
// -----------------------------------------------------------------------------
package etg_pkg;

	localparam int unsigned LEN_W   = 13;
	localparam int unsigned IDX_W   = 12;
	localparam int unsigned LVL_W   = 17;
	localparam int unsigned FRAC_W  = 16;
	localparam int unsigned NUM_W   = 30;
	localparam int unsigned CFG_A_W = 3;
	localparam int unsigned CFG_D_W = 17;

	localparam logic [LEN_W-1:0] TABLE_MAX       = 13'd4096;
	localparam logic [LVL_W-1:0] LEVEL_ONE       = 17'd65536;
	localparam logic [LVL_W-1:0] SUSTAIN_DEFAULT = 17'd21823;

	typedef enum logic [1:0] {
		MODE_AR   = 2'd0,
		MODE_ADR  = 2'd1,
		MODE_ADSR = 2'd2,
		MODE_RSVD = 2'd3
	} mode_t;

	typedef enum logic [CFG_A_W-1:0] {
		REG_TABLE_LENGTH = 3'd0,
		REG_MODE         = 3'd1,
		REG_ATTACK       = 3'd2,
		REG_DECAY        = 3'd3,
		REG_RELEASE      = 3'd4,
		REG_SUSTAIN      = 3'd5
	} reg_idx_t;

	// envelope shape derived from the registers
	typedef struct packed {
		logic [LEN_W-1:0] n;
		logic [LEN_W-1:0] a;
		logic [LEN_W-1:0] d;
		logic [LEN_W-1:0] r;
		logic [LVL_W-1:0] g;
		logic             mode0;
		logic             adsr;
	} shape_t;

	// payload handed along the divider chain
	typedef struct packed {
		logic [NUM_W-1:0] rem;
		logic [LEN_W-1:0] den;
		logic [LVL_W-1:0] q;
		logic [LVL_W-1:0] off;
		logic             err;
	} div_t;

endpackage

>>> hw/rtl/etg_if.sv
// -----------------------------------------------------------------------------
// etg channel interfaces
// Request, response and register write channels with valid/ready.
// -----------------------------------------------------------------------------
interface etg_req_if;
	logic                       valid;
	logic                       ready;
	logic [etg_pkg::IDX_W-1:0]  entry_index;
	modport source (output valid, output entry_index, input ready);
	modport sink   (input valid, input entry_index, output ready);
endinterface

interface etg_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [etg_pkg::LVL_W-1:0]  level;
	logic                       segments_too_long;
	modport source (output valid, output level, output segments_too_long, input ready);
	modport sink   (input valid, input level, input segments_too_long, output ready);
endinterface

interface etg_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [etg_pkg::CFG_A_W-1:0] index;
	logic [etg_pkg::CFG_D_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/etg_cfg.sv
// -----------------------------------------------------------------------------
// etg_cfg
// Register file and derived segment lengths, registered in the cycle after the registers.
// -----------------------------------------------------------------------------
module etg_cfg (
	input  logic              clk,
	input  logic              arst_n,
	etg_cfg_if.sink           cfg,
	output etg_pkg::shape_t   shape
);

	logic [etg_pkg::LEN_W-1:0]  table_length_q;
	logic [1:0]                 mode_q;
	logic [etg_pkg::FRAC_W-1:0] attack_q;
	logic [etg_pkg::FRAC_W-1:0] decay_q;
	logic [etg_pkg::FRAC_W-1:0] release_q;
	logic [etg_pkg::LVL_W-1:0]  sustain_q;
	etg_pkg::shape_t            shape_q;

	logic [etg_pkg::LEN_W-1:0]  n;
	logic [28:0]                prod_a;
	logic [28:0]                prod_d;
	logic [28:0]                prod_r;
	logic                       mode0;
	logic                       adsr;

	assign cfg.ready = 1'b1;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_length_q <= 13'd512;
			mode_q         <= etg_pkg::MODE_ADSR;
			attack_q       <= 16'd6554;
			decay_q        <= 16'd6554;
			release_q      <= 16'd13107;
			sustain_q      <= 17'd21823;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				etg_pkg::REG_TABLE_LENGTH: table_length_q <= cfg.data[etg_pkg::LEN_W-1:0];
				etg_pkg::REG_MODE:         mode_q         <= cfg.data[1:0];
				etg_pkg::REG_ATTACK:       attack_q       <= cfg.data[etg_pkg::FRAC_W-1:0];
				etg_pkg::REG_DECAY:        decay_q        <= cfg.data[etg_pkg::FRAC_W-1:0];
				etg_pkg::REG_RELEASE:      release_q      <= cfg.data[etg_pkg::FRAC_W-1:0];
				etg_pkg::REG_SUSTAIN:      sustain_q      <= cfg.data;
				default: ;
			endcase
		end
	end

	// saturated length and fractional segment products
	always_comb begin
		n      = (table_length_q > etg_pkg::TABLE_MAX) ? etg_pkg::TABLE_MAX : table_length_q;
		prod_a = 29'(n) * 29'(attack_q);
		prod_d = 29'(n) * 29'(decay_q);
		prod_r = 29'(n) * 29'(release_q);
		mode0  = (mode_q == etg_pkg::MODE_AR);
		adsr   = (mode_q != etg_pkg::MODE_ADR);
	end

	// derived shape
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shape_q <= '0;
		end else begin
			shape_q.n     <= n;
			shape_q.a     <= prod_a[28:16];
			shape_q.d     <= mode0 ? '0 : prod_d[28:16];
			shape_q.r     <= (mode0 || !adsr) ? '0 : prod_r[28:16];
			shape_q.mode0 <= mode0;
			shape_q.adsr  <= adsr;
			if (sustain_q == '0)
				shape_q.g <= etg_pkg::SUSTAIN_DEFAULT;
			else if (sustain_q > etg_pkg::LEVEL_ONE)
				shape_q.g <= etg_pkg::LEVEL_ONE;
			else
				shape_q.g <= sustain_q;
		end
	end

	assign shape = shape_q;

endmodule

>>> hw/rtl/etg_front.sv
// -----------------------------------------------------------------------------
// etg_front
// Index register, segment select and numerator multiply ahead of the divider.
// -----------------------------------------------------------------------------
module etg_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  etg_pkg::shape_t            shape,
	etg_req_if.sink                    req,
	output logic                       dn_valid,
	input  logic                       dn_ready,
	output etg_pkg::div_t              dn_data
);

	logic                       v_s1, v_s2, v_s3;
	logic                       en1, en2, en3;
	logic [etg_pkg::IDX_W-1:0]  idx_s1;
	logic [etg_pkg::LVL_W-1:0]  x_s2;
	logic [etg_pkg::LEN_W-1:0]  j_s2;
	logic [etg_pkg::LEN_W-1:0]  den_s2;
	logic [etg_pkg::LVL_W-1:0]  off_s2;
	logic                       err_s2;
	etg_pkg::div_t              data_s3;

	logic [13:0]                i;
	logic [13:0]                n;
	logic [13:0]                ad;
	logic [14:0]                adr;
	logic [13:0]                rs;
	logic                       err;
	logic [etg_pkg::LVL_W-1:0]  x;
	logic [13:0]                j;
	logic [13:0]                den;
	logic [etg_pkg::LVL_W-1:0]  off;

	// stage enables
	assign en3       = !v_s3 || dn_ready;
	assign en2       = !v_s2 || en3;
	assign en1       = !v_s1 || en2;
	assign req.ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= req.valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && req.valid) idx_s1 <= req.entry_index;
	end

	// segment select
	always_comb begin
		i   = 14'(idx_s1);
		n   = 14'(shape.n);
		ad  = 14'(shape.a) + 14'(shape.d);
		adr = 15'(ad) + 15'(shape.r);
		err = !shape.mode0 && (adr >= 15'(n));
		if (shape.mode0)
			rs = 14'(shape.a);
		else if (shape.adsr)
			rs = n - 14'(shape.r);
		else
			rs = ad;
		x   = '0;
		j   = '0;
		den = 14'd1;
		off = '0;
		priority if (err || i >= n) begin
			off = '0;
		end else if (i < 14'(shape.a)) begin
			x   = etg_pkg::LEVEL_ONE;
			j   = i;
			den = 14'(shape.a);
		end else if (i < ad) begin
			x   = etg_pkg::LEVEL_ONE - shape.g;
			j   = ad - i;
			den = 14'(shape.d);
			off = shape.g;
		end else if (i < rs) begin
			off = shape.g;
		end else begin
			x   = shape.mode0 ? etg_pkg::LEVEL_ONE : shape.g;
			j   = n - i;
			den = n - rs;
		end
	end

	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			x_s2   <= x;
			j_s2   <= j[etg_pkg::LEN_W-1:0];
			den_s2 <= den[etg_pkg::LEN_W-1:0];
			off_s2 <= off;
			err_s2 <= err;
		end
	end

	// numerator multiply
	always_ff @(posedge clk) begin
		if (en3 && v_s2) begin
			data_s3.rem <= etg_pkg::NUM_W'(x_s2) * etg_pkg::NUM_W'(j_s2);
			data_s3.den <= den_s2;
			data_s3.q   <= '0;
			data_s3.off <= off_s2;
			data_s3.err <= err_s2;
		end
	end

	assign dn_valid = v_s3;
	assign dn_data  = data_s3;

endmodule

>>> hw/rtl/etg_div_cell.sv
// -----------------------------------------------------------------------------
// etg_div_cell
// One restoring division cell: settles a single quotient bit.
// -----------------------------------------------------------------------------
module etg_div_cell #(
	parameter int unsigned BIT = 0
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           up_valid,
	output logic           up_ready,
	input  etg_pkg::div_t  up_data,
	output logic           dn_valid,
	input  logic           dn_ready,
	output etg_pkg::div_t  dn_data
);

	logic                       v_q;
	etg_pkg::div_t              data_q;
	etg_pkg::div_t              data_d;
	logic                       en;
	logic [etg_pkg::NUM_W-1:0]  shifted;
	logic                       take;

	assign en       = !v_q || dn_ready;
	assign up_ready = en;

	// trial subtract of the shifted divisor
	assign shifted = etg_pkg::NUM_W'(up_data.den) << BIT;
	assign take    = (up_data.rem >= shifted);

	// next payload with this quotient bit settled
	always_comb begin
		data_d = up_data;
		if (take)
			data_d.rem = up_data.rem - shifted;
		data_d.q[BIT] = take;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && up_valid) begin
			data_q <= data_d;
		end
	end

	assign dn_valid = v_q;
	assign dn_data  = data_q;

endmodule

>>> hw/rtl/envelope_table_generator_top.sv
// -----------------------------------------------------------------------------
// envelope_table_generator_top
// Piecewise-linear envelope value for one table index.
// -----------------------------------------------------------------------------
// path: an accepted request passes the index, select and multiply stages,
//   then 17 one-bit divider cells
// throughput: one request per cycle while rsp.ready is high, set by the cell
//   chain taking a new quotient each cycle; a full cell stalls only when the next one does
// reset: registers return to their defaults, the pipeline empties
// -----------------------------------------------------------------------------
module envelope_table_generator_top (
	input  logic       clk,
	input  logic       arst_n,
	etg_cfg_if.sink    cfg,
	etg_req_if.sink    req,
	etg_rsp_if.source  rsp
);

	localparam int unsigned NCELL = etg_pkg::LVL_W;

	etg_pkg::shape_t shape;
	logic            c_valid [NCELL+1];
	logic            c_ready [NCELL+1];
	etg_pkg::div_t   c_data  [NCELL+1];

	etg_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.shape  (shape)
	);

	etg_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.shape    (shape),
		.req      (req),
		.dn_valid (c_valid[0]),
		.dn_ready (c_ready[0]),
		.dn_data  (c_data[0])
	);

	// divider chain, most significant quotient bit first
	for (genvar k = 0; k < NCELL; k++) begin : g_cell
		etg_div_cell #(.BIT(NCELL - 1 - k)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (c_valid[k]),
			.up_ready (c_ready[k]),
			.up_data  (c_data[k]),
			.dn_valid (c_valid[k+1]),
			.dn_ready (c_ready[k+1]),
			.dn_data  (c_data[k+1])
		);
	end

	// response
	assign rsp.valid             = c_valid[NCELL];
	assign c_ready[NCELL]        = rsp.ready;
	assign rsp.level             = c_data[NCELL].q + c_data[NCELL].off;
	assign rsp.segments_too_long = c_data[NCELL].err;

	// checks
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.segments_too_long |-> rsp.level == '0)
		else $error("error response with nonzero level");

	a_level_max: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> rsp.level <= etg_pkg::LEVEL_ONE)
		else $error("level above full scale");

	a_rem_small: assert property (@(posedge clk) disable iff (!arst_n)
		c_valid[NCELL] |-> c_data[NCELL].rem < etg_pkg::NUM_W'(c_data[NCELL].den))
		else $error("divider remainder not below divisor");

endmodule
